// ----- rtl/mlpe_pkg.sv -----
// shared types and constants for the morse letter pulse encoder
// holds the letter tables, register codes, reset values and the descriptor type
// no dependencies
package mlpe_pkg;

   localparam int DUR_W = 12;
   localparam int CHAR_W = 8;
   localparam int LEN_W = 3;
   localparam int PAT_W = 4;
   localparam int SEG_W = 3;
   localparam int N_LETTERS = 26;
   localparam int LETTER_IDX_W = 5;

   localparam logic [CHAR_W-1:0] CHAR_SPACE = 8'h20;
   localparam logic [CHAR_W-1:0] CHAR_LOW_A = 8'h61;
   localparam logic [CHAR_W-1:0] CHAR_LOW_Z = 8'h7a;

   localparam logic [DUR_W-1:0] DASH_MS_RST = 12'd300;
   localparam logic [DUR_W-1:0] DOT_MS_RST = 12'd100;
   localparam logic [DUR_W-1:0] ELEMENT_GAP_MS_RST = 12'd50;
   localparam logic [DUR_W-1:0] LETTER_GAP_MS_RST = 12'd300;

   localparam int CSR_IDX_W = 2;

   typedef enum logic [CSR_IDX_W-1:0] {
      REG_DASH_MS        = 2'd0,
      REG_DOT_MS         = 2'd1,
      REG_ELEMENT_GAP_MS = 2'd2,
      REG_LETTER_GAP_MS  = 2'd3
   } csr_reg_type;

   // element count per letter a to z
   localparam logic [LEN_W-1:0] SYM_LEN [N_LETTERS] = '{
      3'd2, 3'd4, 3'd4, 3'd3, 3'd1, 3'd4, 3'd3, 3'd4, 3'd2, 3'd4, 3'd3, 3'd4, 3'd2,
      3'd2, 3'd3, 3'd4, 3'd4, 3'd3, 3'd3, 3'd1, 3'd3, 3'd4, 3'd3, 3'd4, 3'd4, 3'd4
   };

   // element pattern, first element in the highest used bit, 1 is a dash
   localparam logic [PAT_W-1:0] SYM_BITS [N_LETTERS] = '{
      4'h1, 4'h8, 4'hA, 4'h4, 4'h0, 4'h2, 4'h6, 4'h0, 4'h0, 4'h7, 4'h5, 4'h4, 4'h3,
      4'h2, 4'h7, 4'h6, 4'hD, 4'h2, 4'h0, 4'h1, 4'h1, 4'h1, 4'h3, 4'h9, 4'hB, 4'hC
   };

   typedef struct packed {
      logic             is_space;
      logic [LEN_W-1:0] len;
      logic [PAT_W-1:0] pattern;
   } desc_type;

   typedef struct packed {
      logic [DUR_W-1:0] dash_ms;
      logic [DUR_W-1:0] dot_ms;
      logic [DUR_W-1:0] element_gap_ms;
      logic [DUR_W-1:0] letter_gap_ms;
   } cfg_type;

   typedef struct packed {
      logic     valid;
      desc_type desc;
   } push_type;

endpackage

// ----- rtl/mlpe_front.sv -----
// front end: classifies an incoming character into a segment descriptor
// depends on mlpe_pkg; unsupported characters are dropped here
module mlpe_front
   import mlpe_pkg::*;
(
   input  logic              req_valid,
   input  logic              req_stall,
   input  logic [CHAR_W-1:0] req_character,
   output push_type          push
);

   logic                    is_letter;
   logic                    is_space;
   logic [CHAR_W-1:0]       offset;
   logic [LETTER_IDX_W-1:0] letter_idx;

   always_comb begin
      is_space = (req_character == CHAR_SPACE);
      is_letter = (req_character >= CHAR_LOW_A) && (req_character <= CHAR_LOW_Z);
      offset = req_character - CHAR_LOW_A;
      letter_idx = is_letter ? offset[LETTER_IDX_W-1:0] : '0;

      push.valid = req_valid && !req_stall && (is_letter || is_space);
      push.desc.is_space = is_space;
      push.desc.len = SYM_LEN[letter_idx];
      push.desc.pattern = SYM_BITS[letter_idx];
   end

endmodule

// ----- rtl/mlpe_fifo.sv -----
// short descriptor queue between front and back
// depends on mlpe_pkg for the descriptor type
module mlpe_fifo
   import mlpe_pkg::*;
#(
   parameter int DEPTH = 4
) (
   input  logic     clock,
   input  logic     reset,
   input  push_type push,
   output logic     full,
   output logic     pop_valid,
   output desc_type pop_desc,
   input  logic     pop
);

   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);
   localparam logic [AW-1:0] LAST_PTR = AW'(DEPTH - 1);
   localparam logic [CW-1:0] DEPTH_CNT = CW'(DEPTH);

   desc_type        mem [DEPTH];
   logic [AW-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [AW-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0]   count_ff, count_in;
   logic            do_pop;

   always_comb begin
      full = (count_ff == DEPTH_CNT);
      pop_valid = (count_ff != '0);
      pop_desc = mem[rd_ptr_ff];
      do_pop = pop && pop_valid;

      wr_ptr_in = wr_ptr_ff;
      if (push.valid) begin
         wr_ptr_in = (wr_ptr_ff == LAST_PTR) ? '0 : wr_ptr_ff + 1'b1;
      end
      rd_ptr_in = rd_ptr_ff;
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == LAST_PTR) ? '0 : rd_ptr_ff + 1'b1;
      end
      count_in = count_ff;
      if (push.valid && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (!push.valid && do_pop) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (push.valid) begin
         mem[wr_ptr_ff] <= push.desc;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff <= count_in;
      end
   end

endmodule

// ----- rtl/mlpe_back.sv -----
// back end: steps through the segments of one descriptor, one per cycle while the result side does not stall
// depends on mlpe_pkg; drives the registered result channel
module mlpe_back
   import mlpe_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  cfg_type          cfg,
   input  logic             q_valid,
   input  desc_type         q_desc,
   output logic             q_pop,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output logic             rsp_led_on,
   output logic [DUR_W-1:0] rsp_duration_ms,
   output logic             rsp_last_segment
);

   typedef enum logic [1:0] {
      ST_IDLE = 2'b01,
      ST_RUN  = 2'b10
   } state_type;

   state_type        state_ff, state_in;
   desc_type         desc_ff, desc_in;
   logic [SEG_W-1:0] seg_ff, seg_in;
   logic             rsp_valid_ff, rsp_valid_in;
   logic             led_ff, led_in;
   logic [DUR_W-1:0] dur_ff, dur_in;
   logic             last_ff, last_in;

   logic             emit;
   logic             seg_on;
   logic [DUR_W-1:0] seg_dur;
   logic             seg_last;
   logic [LEN_W-1:0] bit_pos;
   logic [LEN_W-1:0] last_seg_idx;

   always_comb begin
      // letter: on and off alternate, 2*len segments, the last one the letter gap
      bit_pos = desc_ff.len - 3'd1 - {1'b0, seg_ff[2:1]};
      last_seg_idx = {desc_ff.len[1:0], 1'b0} - 3'd1;
      if (desc_ff.is_space) begin
         seg_on = 1'b0;
         seg_dur = cfg.letter_gap_ms;
         seg_last = (seg_ff == 3'd1);
      end else if (seg_ff == last_seg_idx) begin
         seg_on = 1'b0;
         seg_dur = cfg.letter_gap_ms;
         seg_last = 1'b1;
      end else if (seg_ff[0]) begin
         seg_on = 1'b0;
         seg_dur = cfg.element_gap_ms;
         seg_last = 1'b0;
      end else begin
         seg_on = 1'b1;
         seg_dur = desc_ff.pattern[bit_pos[1:0]] ? cfg.dash_ms : cfg.dot_ms;
         seg_last = 1'b0;
      end

      emit = (state_ff == ST_RUN) && (!rsp_valid_ff || !rsp_stall);
      q_pop = q_valid && ((state_ff == ST_IDLE) || (emit && seg_last));

      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (q_pop) begin
               state_in = ST_RUN;
            end
         end
         ST_RUN: begin
            if (emit && seg_last && !q_pop) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase

      desc_in = desc_ff;
      seg_in = seg_ff;
      if (q_pop) begin
         desc_in = q_desc;
         seg_in = '0;
      end else if (emit) begin
         seg_in = seg_ff + 1'b1;
      end

      rsp_valid_in = rsp_valid_ff && rsp_stall;
      led_in = led_ff;
      dur_in = dur_ff;
      last_in = last_ff;
      if (emit) begin
         rsp_valid_in = 1'b1;
         led_in = seg_on;
         dur_in = seg_dur;
         last_in = seg_last;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      desc_ff <= desc_in;
      seg_ff <= seg_in;
      led_ff <= led_in;
      dur_ff <= dur_in;
      last_ff <= last_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_led_on = led_ff;
   assign rsp_duration_ms = dur_ff;
   assign rsp_last_segment = last_ff;

endmodule

// ----- rtl/morse_letter_pulse_encoder.sv -----
// top level of the morse letter pulse encoder
// depends on mlpe_pkg, mlpe_front, mlpe_fifo and mlpe_back
//
// Takes one ASCII character per request and returns its Morse code as timed LED
// segments (level, duration in ms, last-segment flag). Letters a to z give 2 to 8
// segments, a space gives two letter gaps and any other code gives none. The
// sequencer in the back end emits one segment per cycle while the result side
// does not stall; requests are classified and queued in QUEUE_DEPTH entries
// ahead of it, so the request side stalls only when the queue is full. The user
// must write the four duration registers over the csr port while idle (not enforced).
module morse_letter_pulse_encoder
   import mlpe_pkg::*;
#(
   parameter int QUEUE_DEPTH = 4
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  logic [CHAR_W-1:0]    req_character,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output logic                 rsp_led_on,
   output logic [DUR_W-1:0]     rsp_duration_ms,
   output logic                 rsp_last_segment,
   input  logic                 csr_valid,
   output logic                 csr_ready,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [DUR_W-1:0]     csr_data
);

   cfg_type  cfg_ff, cfg_in;
   push_type push;
   logic     q_full;
   logic     q_valid;
   desc_type q_desc;
   logic     q_pop;

   assign csr_ready = 1'b1;
   assign req_stall = q_full;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid && csr_ready) begin
         unique case (csr_reg_type'(csr_index))
            REG_DASH_MS:        cfg_in.dash_ms = csr_data;
            REG_DOT_MS:         cfg_in.dot_ms = csr_data;
            REG_ELEMENT_GAP_MS: cfg_in.element_gap_ms = csr_data;
            REG_LETTER_GAP_MS:  cfg_in.letter_gap_ms = csr_data;
            default:            cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.dash_ms <= DASH_MS_RST;
         cfg_ff.dot_ms <= DOT_MS_RST;
         cfg_ff.element_gap_ms <= ELEMENT_GAP_MS_RST;
         cfg_ff.letter_gap_ms <= LETTER_GAP_MS_RST;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   mlpe_front u_front (
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_character (req_character),
      .push          (push)
   );

   mlpe_fifo #(
      .DEPTH (QUEUE_DEPTH)
   ) u_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .full      (q_full),
      .pop_valid (q_valid),
      .pop_desc  (q_desc),
      .pop       (q_pop)
   );

   mlpe_back u_back (
      .clock            (clock),
      .reset            (reset),
      .cfg              (cfg_ff),
      .q_valid          (q_valid),
      .q_desc           (q_desc),
      .q_pop            (q_pop),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_led_on       (rsp_led_on),
      .rsp_duration_ms  (rsp_duration_ms),
      .rsp_last_segment (rsp_last_segment)
   );

endmodule

// ----- rtl/mlpe_checker.sv -----
// port-level checks for the morse letter pulse encoder
// depends on mlpe_pkg; bound to the top level below
module mlpe_checker
   import mlpe_pkg::*;
(
   input logic             clock,
   input logic             reset,
   input logic             rsp_valid,
   input logic             rsp_stall,
   input logic             rsp_led_on,
   input logic [DUR_W-1:0] rsp_duration_ms,
   input logic             rsp_last_segment
);

   logic prev_on_ff;

   // level of the last segment taken on the result side
   always_ff @(posedge clock) begin
      if (reset) begin
         prev_on_ff <= 1'b0;
      end else if (rsp_valid && !rsp_stall) begin
         prev_on_ff <= rsp_led_on;
      end
   end

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_led_on)
         && $stable(rsp_duration_ms) && $stable(rsp_last_segment))
      else $error("stalled result changed");

   a_on_not_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !(rsp_led_on && rsp_last_segment))
      else $error("on segment flagged as last");

   a_on_then_off: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && prev_on_ff |-> !rsp_led_on)
      else $error("two on segments in a row");

   a_reset_quiet: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid straight after reset");

endmodule

bind morse_letter_pulse_encoder mlpe_checker u_mlpe_checker (.*);

// ----- tb/testbench.sv -----
// testbench for the morse letter pulse encoder: directed and random characters
// under several duration settings, with a scoreboard that predicts every segment
// depends on mlpe_pkg and morse_letter_pulse_encoder
module testbench;
   import mlpe_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int HOLD_OFF = 24;
   localparam int WATCHDOG_LIMIT = 2000;
   localparam int PHASE_ITEMS = 25;

   typedef struct {
      bit            led_on;
      bit [DUR_W-1:0] duration_ms;
      bit            last_segment;
   } segment_type;

   // predicts the segments of each accepted character and checks them in order
   class segment_board;
      segment_type pending [$];
      int mismatches = 0;
      bit [DUR_W-1:0] dash_ms = DASH_MS_RST;
      bit [DUR_W-1:0] dot_ms = DOT_MS_RST;
      bit [DUR_W-1:0] element_gap_ms = ELEMENT_GAP_MS_RST;
      bit [DUR_W-1:0] letter_gap_ms = LETTER_GAP_MS_RST;
      string morse [26] = '{
         ".-", "-...", "-.-.", "-..", ".", "..-.", "--.", "....", "..", ".---",
         "-.-", ".-..", "--", "-.", "---", ".--.", "--.-", ".-.", "...", "-",
         "..-", "...-", ".--", "-..-", "-.--", "--.."
      };

      function void set_register(csr_reg_type index, bit [DUR_W-1:0] value);
         case (index)
            REG_DASH_MS:        dash_ms = value;
            REG_DOT_MS:         dot_ms = value;
            REG_ELEMENT_GAP_MS: element_gap_ms = value;
            REG_LETTER_GAP_MS:  letter_gap_ms = value;
            default: ;
         endcase
      endfunction

      function void push_segment(bit led_on, bit [DUR_W-1:0] duration_ms, bit last_segment);
         segment_type seg;
         seg.led_on = led_on;
         seg.duration_ms = duration_ms;
         seg.last_segment = last_segment;
         pending.push_back(seg);
      endfunction

      function void note_request(bit [CHAR_W-1:0] character);
         string code;
         int k;
         if (character == CHAR_SPACE) begin
            push_segment(1'b0, letter_gap_ms, 1'b0);
            push_segment(1'b0, letter_gap_ms, 1'b1);
         end else if (character >= CHAR_LOW_A && character <= CHAR_LOW_Z) begin
            code = morse[character - CHAR_LOW_A];
            for (k = 0; k < code.len(); k++) begin
               if (k > 0) push_segment(1'b0, element_gap_ms, 1'b0);
               push_segment(1'b1, (code[k] == "-") ? dash_ms : dot_ms, 1'b0);
            end
            push_segment(1'b0, letter_gap_ms, 1'b1);
         end
         // anything else produces no segments
      endfunction

      function void check_segment(bit led_on, bit [DUR_W-1:0] duration_ms, bit last_segment);
         segment_type want;
         if (pending.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("unexpected segment: led_on %0b duration %0d last %0b",
                        led_on, duration_ms, last_segment);
            return;
         end
         want = pending.pop_front();
         if (want.led_on !== led_on || want.duration_ms !== duration_ms
             || want.last_segment !== last_segment) begin
            mismatches++;
            if (mismatches <= 10) begin
               $display("segment mismatch: expected led_on %0b duration %0d last %0b",
                        want.led_on, want.duration_ms, want.last_segment);
               $display("   got led_on %0b duration %0d last %0b",
                        led_on, duration_ms, last_segment);
            end
         end
      endfunction
   endclass

   logic                 clock = 1'b0;
   logic                 reset = 1'b1;
   logic                 req_valid = 1'b0;
   logic                 req_stall;
   logic [CHAR_W-1:0]    req_character = '0;
   logic                 rsp_valid;
   logic                 rsp_stall = 1'b1;
   logic                 rsp_led_on;
   logic [DUR_W-1:0]     rsp_duration_ms;
   logic                 rsp_last_segment;
   logic                 csr_valid = 1'b0;
   logic                 csr_ready;
   logic [CSR_IDX_W-1:0] csr_index = '0;
   logic [DUR_W-1:0]     csr_data = '0;

   segment_board board = new;
   bit steady = 1'b0;
   int idle_cycles = 0;

   morse_letter_pulse_encoder i_dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_character    (req_character),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_led_on       (rsp_led_on),
      .rsp_duration_ms  (rsp_duration_ms),
      .rsp_last_segment (rsp_last_segment),
      .csr_valid        (csr_valid),
      .csr_ready        (csr_ready),
      .csr_index        (csr_index),
      .csr_data         (csr_data)
   );

   always #4 clock = ~clock;

   // no handshake of any kind for too long means the block has hung
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)
          || (csr_valid && csr_ready)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("testbench NOT OK");
            $finish;
         end
      end
   end

   task automatic send_character(bit [CHAR_W-1:0] character);
      int gap;
      gap = steady ? 0 : $urandom_range(0, 6);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_character <= character;
      do @(posedge clock); while (req_stall);
      board.note_request(character);
   endtask

   // leaves csr_valid high so that writes can follow back to back
   task automatic write_register(csr_reg_type index, bit [DUR_W-1:0] value);
      csr_valid <= 1'b1;
      csr_index <= index;
      csr_data <= value;
      do @(posedge clock); while (!csr_ready);
      board.set_register(index, value);
   endtask

   task automatic write_durations(bit [DUR_W-1:0] dash, bit [DUR_W-1:0] dot,
                                  bit [DUR_W-1:0] element_gap, bit [DUR_W-1:0] letter_gap);
      write_register(REG_DASH_MS, dash);
      write_register(REG_DOT_MS, dot);
      write_register(REG_ELEMENT_GAP_MS, element_gap);
      write_register(REG_LETTER_GAP_MS, letter_gap);
      csr_valid <= 1'b0;
   endtask

   // drain every expected segment, then let the block idle for the hold-off period
   task automatic wait_drained();
      req_valid <= 1'b0;
      while (board.pending.size() != 0) @(posedge clock);
      repeat (HOLD_OFF) @(posedge clock);
   endtask

   function automatic bit [CHAR_W-1:0] draw_character();
      int pick;
      pick = $urandom_range(0, 9);
      if (pick < 7) return CHAR_W'(CHAR_LOW_A + $urandom_range(0, 25));
      if (pick == 7) return CHAR_SPACE;
      return CHAR_W'($urandom_range(0, 255));
   endfunction

   function automatic bit [DUR_W-1:0] draw_duration();
      case ($urandom_range(0, 5))
         0: return 12'd1;
         1: return 12'hfff;
         2: return DUR_W'($urandom_range(0, 15));
         default: return DUR_W'($urandom_range(0, 4095));
      endcase
   endfunction

   // result side: random stall before each segment, none in the steady phases
   initial begin : result_side
      int gap;
      @(negedge reset);
      forever begin
         gap = steady ? 0 : $urandom_range(0, 6);
         if (gap > 0) begin
            rsp_stall <= 1'b1;
            repeat (gap) @(posedge clock);
         end
         rsp_stall <= 1'b0;
         do @(posedge clock); while (!rsp_valid);
         board.check_segment(rsp_led_on, rsp_duration_ms, rsp_last_segment);
      end
   end

   initial begin : stimulus
      bit [CHAR_W-1:0] directed [$];
      int phase;
      int n;
      directed = '{8'h20, 8'h61, 8'h65, 8'h74, 8'h71, 8'h7a, 8'h68, 8'h6f, 8'h41,
                   8'h00, 8'hff, 8'h60, 8'h7b, 8'h1f, 8'h21, 8'h6d, 8'h79, 8'h6a,
                   8'h62, 8'h78, 8'h20, 8'h20, 8'h73};
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // reset durations first
      for (n = 0; n < directed.size(); n++) send_character(directed[n]);

      for (phase = 0; phase < 8; phase++) begin
         wait_drained();
         case (phase)
            0: write_durations(12'hfff, 12'hfff, 12'hfff, 12'hfff);
            1: write_durations(12'd1, 12'd1, 12'd1, 12'd1);
            2: write_durations(12'd0, 12'hfff, 12'd0, 12'd1);
            default: write_durations(draw_duration(), draw_duration(),
                                     draw_duration(), draw_duration());
         endcase
         steady = (phase == 1 || phase == 5);
         if (phase == 0) begin
            // every letter once under the widest durations
            for (n = 0; n < 26; n++) send_character(CHAR_W'(CHAR_LOW_A + n));
         end else begin
            for (n = 0; n < (phase < 3 ? 12 : PHASE_ITEMS); n++)
               send_character(draw_character());
         end
      end
      steady = 1'b0;

      wait_drained();
      if (board.pending.size() != 0)
         $display("%0d expected segments never arrived", board.pending.size());
      if (board.mismatches == 0 && board.pending.size() == 0) begin
         $display("testbench OK");
      end else begin
         $display("testbench NOT OK");
      end
      $finish;
   end

endmodule
